/* hw/rtl/assert_macros.svh */
// concurrent assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define CSRB_ASSERT(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define CSRB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`else

`define CSRB_ASSERT(name, clk, rst_n, cond)
`define CSRB_ASSERT_IMP(name, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/csrb_pkg.sv */
// shared constants, codes and beat types of the csr builder
package csrb_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int MAX_EDGES    = 1024;
	localparam int NBR_SLOTS    = 2 * MAX_EDGES;

	localparam int VID_W  = 10;
	localparam int VC_W   = 11;
	localparam int RIDX_W = 11;
	localparam int ECNT_W = 11;
	localparam int OFF_W  = 12;
	localparam int EIDX_W = $clog2(MAX_EDGES);
	localparam int NV_W   = $clog2(MAX_VERTICES + 1);
	localparam int OFF_AW = $clog2(MAX_VERTICES + 1);
	localparam int NBR_AW = $clog2(NBR_SLOTS);
	localparam int IDX_W  = (NV_W > ECNT_W) ? NV_W : ECNT_W;

	localparam logic [2:0] KIND_CLEAR    = 3'd0;
	localparam logic [2:0] KIND_LOAD     = 3'd1;
	localparam logic [2:0] KIND_BUILD    = 3'd2;
	localparam logic [2:0] KIND_READ_OFF = 3'd3;
	localparam logic [2:0] KIND_READ_NBR = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_BADREAD = 2'd3;

	typedef struct packed {
		logic [2:0]        kind;
		logic [VID_W-1:0]  vertex_a;
		logic [VID_W-1:0]  vertex_b;
		logic [RIDX_W-1:0] read_index;
	} item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [OFF_W-1:0]  value;
		logic [ECNT_W-1:0] edge_total;
	} result_t;

	typedef struct packed {
		logic [VID_W-1:0] a;
		logic [VID_W-1:0] b;
	} edge_t;

	typedef struct packed {
		logic [EIDX_W-1:0] edge_raddr;
		logic              off_we;
		logic [OFF_AW-1:0] off_waddr;
		logic [OFF_W-1:0]  off_wdata;
		logic              nbr_we;
		logic [NBR_AW-1:0] nbr_waddr;
		logic [VID_W-1:0]  nbr_wdata;
		logic              done;
	} bld_mem_t;

endpackage

/* hw/rtl/csrb_ram.sv */
// generic single write, single read ram with registered read data
module csrb_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/csrb_build.sv */
// build sequencer: degree count, prefix sum and neighbor scatter over the cursor ram
module csrb_build (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [csrb_pkg::NV_W-1:0]   nv,
	input  logic [csrb_pkg::ECNT_W-1:0] edge_count,
	input  csrb_pkg::edge_t             edge_rdata,
	output csrb_pkg::bld_mem_t          bld,
	output logic [csrb_pkg::OFF_W-1:0]  total
);
	import csrb_pkg::*;

	localparam logic [3:0] B_IDLE  = 4'd0;
	localparam logic [3:0] B_ZERO  = 4'd1;
	localparam logic [3:0] B_EREAD = 4'd2;
	localparam logic [3:0] B_EDATA = 4'd3;
	localparam logic [3:0] B_UPA   = 4'd4;
	localparam logic [3:0] B_UPB   = 4'd5;
	localparam logic [3:0] B_SCAN  = 4'd6;
	localparam logic [3:0] B_LAST  = 4'd7;
	localparam logic [3:0] B_DONE  = 4'd8;

	logic [3:0]       state_q;
	logic             pass_q;
	logic [IDX_W-1:0] idx_q;
	logic             scan_v_s1;
	logic [VID_W-1:0] scan_i_s1;
	logic [VID_W-1:0] a_q;
	logic [VID_W-1:0] b_q;
	logic [OFF_W-1:0] fwd_q;
	logic [OFF_W-1:0] acc_q;
	logic [OFF_W-1:0] total_q;

	logic             cnt_we;
	logic [VID_W-1:0] cnt_waddr;
	logic [OFF_W-1:0] cnt_wdata;
	logic [VID_W-1:0] cnt_raddr;
	logic [OFF_W-1:0] cnt_rdata;

	logic             edge_ok;
	logic             edges_done;
	logic [OFF_W-1:0] cur_b;
	logic [OFF_W-1:0] scan_d;

	csrb_ram #(
		.DEPTH(MAX_VERTICES),
		.WIDTH(OFF_W)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	assign edge_ok    = (NV_W'(edge_rdata.a) < nv) && (NV_W'(edge_rdata.b) < nv);
	assign edges_done = (idx_q == IDX_W'(edge_count));
	// same endpoint twice: the read of b missed the write of a
	assign cur_b      = (b_q == a_q) ? fwd_q : cnt_rdata;
	assign scan_d     = (NV_W'(scan_i_s1) < nv) ? cnt_rdata : '0;
	assign total      = total_q;

	always_comb begin
		bld       = '0;
		cnt_we    = 1'b0;
		cnt_waddr = '0;
		cnt_wdata = '0;
		cnt_raddr = '0;
		case (state_q)
			B_ZERO: begin
				cnt_we    = 1'b1;
				cnt_waddr = idx_q[VID_W-1:0];
			end
			B_EREAD: begin
				bld.edge_raddr = idx_q[EIDX_W-1:0];
			end
			B_EDATA: begin
				cnt_raddr = edge_rdata.a;
			end
			B_UPA: begin
				cnt_we        = 1'b1;
				cnt_waddr     = a_q;
				cnt_wdata     = cnt_rdata + OFF_W'(1);
				cnt_raddr     = b_q;
				bld.nbr_we    = pass_q && (cnt_rdata < OFF_W'(NBR_SLOTS));
				bld.nbr_waddr = cnt_rdata[NBR_AW-1:0];
				bld.nbr_wdata = b_q;
			end
			B_UPB: begin
				cnt_we        = 1'b1;
				cnt_waddr     = b_q;
				cnt_wdata     = cur_b + OFF_W'(1);
				bld.nbr_we    = pass_q && (cur_b < OFF_W'(NBR_SLOTS));
				bld.nbr_waddr = cur_b[NBR_AW-1:0];
				bld.nbr_wdata = a_q;
			end
			B_SCAN: begin
				cnt_raddr = idx_q[VID_W-1:0];
				if (scan_v_s1) begin
					cnt_we        = 1'b1;
					cnt_waddr     = scan_i_s1;
					cnt_wdata     = acc_q;
					bld.off_we    = 1'b1;
					bld.off_waddr = OFF_AW'(scan_i_s1);
					bld.off_wdata = acc_q;
				end
			end
			B_LAST: begin
				bld.off_we    = 1'b1;
				bld.off_waddr = OFF_AW'(MAX_VERTICES);
				bld.off_wdata = acc_q;
			end
			B_DONE: begin
				bld.done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			pass_q    <= 1'b0;
			idx_q     <= '0;
			scan_v_s1 <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (start) begin
						state_q <= B_ZERO;
						pass_q  <= 1'b0;
						idx_q   <= '0;
					end
				end
				B_ZERO: begin
					if (idx_q == IDX_W'(MAX_VERTICES - 1)) begin
						idx_q   <= '0;
						state_q <= B_EREAD;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				B_EREAD: begin
					if (edges_done) begin
						idx_q     <= '0;
						scan_v_s1 <= 1'b0;
						state_q   <= pass_q ? B_DONE : B_SCAN;
					end else begin
						state_q <= B_EDATA;
					end
				end
				B_EDATA: begin
					if (edge_ok) begin
						state_q <= B_UPA;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= B_EREAD;
					end
				end
				B_UPA: begin
					state_q <= B_UPB;
				end
				B_UPB: begin
					idx_q   <= idx_q + IDX_W'(1);
					state_q <= B_EREAD;
				end
				B_SCAN: begin
					if (idx_q != IDX_W'(MAX_VERTICES)) begin
						scan_v_s1 <= 1'b1;
						idx_q     <= idx_q + IDX_W'(1);
					end else begin
						scan_v_s1 <= 1'b0;
						state_q   <= B_LAST;
					end
				end
				B_LAST: begin
					pass_q  <= 1'b1;
					idx_q   <= '0;
					state_q <= B_EREAD;
				end
				B_DONE: begin
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_EDATA) begin
			a_q <= edge_rdata.a;
			b_q <= edge_rdata.b;
		end
		if (state_q == B_UPA) begin
			fwd_q <= cnt_rdata + OFF_W'(1);
		end
		if (state_q == B_EREAD && edges_done) begin
			acc_q <= '0;
		end else if (state_q == B_SCAN && scan_v_s1) begin
			acc_q <= acc_q + scan_d;
		end
		if (state_q == B_SCAN) begin
			scan_i_s1 <= idx_q[VID_W-1:0];
		end
		if (state_q == B_LAST) begin
			total_q <= acc_q;
		end
	end

endmodule

/* hw/rtl/edge_list_to_csr_builder_unit.sv */
// top level of the undirected edge list to csr adjacency builder
//
// channel  direction  beat                         accepted when
// item     in         csrb_pkg::item_t             item_valid & item_ready
// result   out        csrb_pkg::result_t           result_valid & result_ready
// cfg      in         vertex_count, 11 bits        cfg_valid & cfg_ready (always ready)
//
// clear, load and unused kinds go straight to the finished state; offset and neighbor reads
// pass a read state first, since the offset and neighbor rams have a registered read.
// in a build, the cursor ram is read-modify-written twice per in-range edge and pass.
// item_ready drops during a read or a build, and while a finished result waits on a stall.
// no clearing pass after reset; the result register holds under result stall.
`include "assert_macros.svh"

module edge_list_to_csr_builder_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  csrb_pkg::item_t           item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output csrb_pkg::result_t         result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [csrb_pkg::VC_W-1:0] cfg_data
);
	import csrb_pkg::*;

	localparam logic [1:0] T_IDLE  = 2'd0;
	localparam logic [1:0] T_READ  = 2'd1;
	localparam logic [1:0] T_BUILD = 2'd2;
	localparam logic [1:0] T_FIN   = 2'd3;

	logic [1:0]        t_state_q;
	logic [VC_W-1:0]   vc_q;
	logic [ECNT_W-1:0] edge_count_q;
	logic              built_q;
	logic              result_valid_q;
	result_t           res_q;
	result_t           result_q;
	logic              rd_nbr_q;

	logic [NV_W-1:0]   nv;
	logic              accept;
	logic              out_free;
	logic              fin_move;
	logic              ld_range;
	logic              ld_full;
	logic              ld_store;
	logic              rd_off_ok;
	logic              rd_nbr_ok;
	logic [1:0]        acc_status;
	logic [ECNT_W-1:0] next_count;
	logic              bld_start;

	bld_mem_t          bld;
	logic [OFF_W-1:0]  bld_total;
	edge_t             edge_wdata;
	edge_t             edge_rdata;
	logic [OFF_W-1:0]  off_rdata;
	logic [VID_W-1:0]  nbr_rdata;

	assign nv = (vc_q > VC_W'(MAX_VERTICES)) ? NV_W'(MAX_VERTICES) : NV_W'(vc_q);

	assign out_free   = !result_valid_q || result_ready;
	assign fin_move   = (t_state_q == T_FIN) && out_free;
	assign item_ready = (t_state_q == T_IDLE) || fin_move;
	assign accept     = item_valid && item_ready;
	assign cfg_ready  = 1'b1;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign ld_range  = (NV_W'(item.vertex_a) >= nv) || (NV_W'(item.vertex_b) >= nv);
	assign ld_full   = (edge_count_q == ECNT_W'(MAX_EDGES));
	assign ld_store  = accept && (item.kind == KIND_LOAD) && !ld_range && !ld_full;
	assign rd_off_ok = built_q && (NV_W'(item.read_index) <= nv);
	assign rd_nbr_ok = built_q && (OFF_W'(item.read_index) < bld_total);
	assign bld_start = accept && (item.kind == KIND_BUILD);

	always_comb begin
		acc_status = ST_OK;
		next_count = edge_count_q;
		case (item.kind)
			KIND_CLEAR: begin
				next_count = '0;
			end
			KIND_LOAD: begin
				if (ld_range) begin
					acc_status = ST_RANGE;
				end else if (ld_full) begin
					acc_status = ST_FULL;
				end else begin
					next_count = edge_count_q + ECNT_W'(1);
				end
			end
			KIND_READ_OFF: begin
				acc_status = rd_off_ok ? ST_OK : ST_BADREAD;
			end
			KIND_READ_NBR: begin
				acc_status = rd_nbr_ok ? ST_OK : ST_BADREAD;
			end
			default: begin
			end
		endcase
	end

	assign edge_wdata = '{a: item.vertex_a, b: item.vertex_b};

	csrb_ram #(
		.DEPTH(MAX_EDGES),
		.WIDTH(2 * VID_W)
	) u_edge_ram (
		.clk  (clk),
		.we   (ld_store),
		.waddr(edge_count_q[EIDX_W-1:0]),
		.wdata(edge_wdata),
		.raddr(bld.edge_raddr),
		.rdata(edge_rdata)
	);

	csrb_ram #(
		.DEPTH(MAX_VERTICES + 1),
		.WIDTH(OFF_W)
	) u_off_ram (
		.clk  (clk),
		.we   (bld.off_we),
		.waddr(bld.off_waddr),
		.wdata(bld.off_wdata),
		.raddr(item.read_index[OFF_AW-1:0]),
		.rdata(off_rdata)
	);

	csrb_ram #(
		.DEPTH(NBR_SLOTS),
		.WIDTH(VID_W)
	) u_nbr_ram (
		.clk  (clk),
		.we   (bld.nbr_we),
		.waddr(bld.nbr_waddr),
		.wdata(bld.nbr_wdata),
		.raddr(item.read_index[NBR_AW-1:0]),
		.rdata(nbr_rdata)
	);

	csrb_build u_build (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (bld_start),
		.nv        (nv),
		.edge_count(edge_count_q),
		.edge_rdata(edge_rdata),
		.bld       (bld),
		.total     (bld_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_state_q      <= T_IDLE;
			vc_q           <= VC_W'(1024);
			edge_count_q   <= '0;
			built_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vc_q <= cfg_data;
			end
			if (fin_move) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (accept) begin
				edge_count_q <= next_count;
				if (item.kind == KIND_CLEAR || ld_store) begin
					built_q <= 1'b0;
				end
				if (item.kind == KIND_BUILD) begin
					t_state_q <= T_BUILD;
				end else if (item.kind inside {KIND_READ_OFF, KIND_READ_NBR}) begin
					t_state_q <= T_READ;
				end else begin
					t_state_q <= T_FIN;
				end
			end else if (fin_move) begin
				t_state_q <= T_IDLE;
			end else if (t_state_q == T_READ) begin
				t_state_q <= T_FIN;
			end else if (t_state_q == T_BUILD && bld.done) begin
				built_q   <= 1'b1;
				t_state_q <= T_FIN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_move) begin
			result_q <= res_q;
		end
		if (accept) begin
			res_q.status     <= acc_status;
			res_q.value      <= '0;
			res_q.edge_total <= next_count;
			rd_nbr_q         <= (item.kind == KIND_READ_NBR);
		end else if (t_state_q == T_READ) begin
			if (res_q.status == ST_OK) begin
				res_q.value <= rd_nbr_q ? OFF_W'(nbr_rdata) : off_rdata;
			end
		end else if (t_state_q == T_BUILD && bld.done) begin
			res_q.status     <= ST_OK;
			res_q.value      <= '0;
			res_q.edge_total <= edge_count_q;
		end
	end

	`CSRB_ASSERT(a_count_cap, clk, arst_n, edge_count_q <= ECNT_W'(MAX_EDGES))
	`CSRB_ASSERT_IMP(a_done_in_build, clk, arst_n, bld.done, t_state_q == T_BUILD)
	`CSRB_ASSERT_IMP(a_writes_in_build, clk, arst_n, bld.nbr_we || bld.off_we, t_state_q == T_BUILD)
	`CSRB_ASSERT_IMP(a_result_from_fin, clk, arst_n, $rose(result_valid_q), $past(t_state_q) == T_FIN)

endmodule
